### rtl/sledg_pkg.sv
package sledg_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned LEVEL_W     = 8;
    localparam int unsigned MS_W        = 16;
    localparam int unsigned TIME_W      = 32;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_SET_MODE = 2'd1,
        OP_PULSE    = 2'd2,
        OP_ACTIVITY = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        MODE_OFF       = 3'd0,
        MODE_STANDBY   = 3'd1,
        MODE_RECONNECT = 3'd2,
        MODE_PAIRING   = 3'd3,
        MODE_CONNECTED = 3'd4,
        MODE_FATAL     = 3'd5
    } t_mode;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_STANDBY_LEVEL = 3'd0,
        CFG_DIM_LEVEL     = 3'd1,
        CFG_MAX_LEVEL     = 3'd2,
        CFG_ACT_PULSE_MS  = 3'd3,
        CFG_ACT_GAP_MS    = 3'd4
    } t_cfg_index;

    localparam logic [11:0] STANDBY_PERIOD   = 12'd4000;
    localparam logic [11:0] STANDBY_ON       = 12'd60;
    localparam logic [10:0] RECONNECT_PERIOD = 11'd1200;
    localparam logic [10:0] RECONNECT_ON     = 11'd80;
    localparam logic [10:0] RECONNECT_GAP    = 11'd160;
    localparam logic [9:0]  PAIRING_PERIOD   = 10'd1000;
    localparam logic [9:0]  PAIRING_ON       = 10'd180;
    localparam logic [9:0]  FATAL_PERIOD     = 10'd900;
    localparam logic [9:0]  FATAL_FLASH      = 10'd100;
    localparam logic [9:0]  FATAL_SECOND     = 10'd300;
    localparam logic [9:0]  FATAL_THIRD      = 10'd500;

    // x/3 for 8-bit x as (x*171)>>9, exact over the whole range
    localparam logic [7:0]  AMBER_RECIP      = 8'd171;
    localparam int unsigned AMBER_SHIFT      = 9;

    typedef struct packed {
        logic [11:0] standby;
        logic [10:0] reconnect;
        logic [9:0]  pairing;
        logic [9:0]  fatal;
    } t_phases;

    typedef struct packed {
        logic [LEVEL_W-1:0] standby_level;
        logic [LEVEL_W-1:0] dim_level;
        logic [LEVEL_W-1:0] max_level;
    } t_levels;

    // blue in the top byte, red in the bottom, as it leaves on tdata
    typedef struct packed {
        logic [LEVEL_W-1:0] blue;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] red;
    } t_rgb;

    function automatic logic [LEVEL_W-1:0] standby_green(input logic [LEVEL_W-1:0] lvl);
        logic [2*LEVEL_W-1:0] prod;
        logic [LEVEL_W-1:0]   third;
        prod  = {8'd0, lvl} * {8'd0, AMBER_RECIP};
        third = 8'(prod >> AMBER_SHIFT);
        return third + 8'd1;
    endfunction

endpackage

### rtl/sledg_colour.sv
module sledg_colour (
    input  logic [2:0]            i_mode,
    input  sledg_pkg::t_phases    i_phases,
    input  sledg_pkg::t_levels    i_levels,
    input  logic                  i_overlay,
    output sledg_pkg::t_rgb       o_rgb
);
    import sledg_pkg::*;

    t_rgb pat;
    logic recon_on;
    logic fatal_on;

    assign recon_on = (i_phases.reconnect < RECONNECT_ON) ||
                      ((i_phases.reconnect >= RECONNECT_GAP) &&
                       (i_phases.reconnect < RECONNECT_GAP + RECONNECT_ON));

    assign fatal_on = (i_phases.fatal < FATAL_FLASH) ||
                      ((i_phases.fatal >= 10'(2 * FATAL_FLASH)) &&
                       (i_phases.fatal < FATAL_SECOND)) ||
                      ((i_phases.fatal >= 10'(4 * FATAL_FLASH)) &&
                       (i_phases.fatal < FATAL_THIRD));

    always_comb begin
        pat = '0;
        case (i_mode)
            MODE_STANDBY: begin
                if (i_phases.standby < STANDBY_ON) begin
                    pat.red   = i_levels.standby_level;
                    pat.green = standby_green(i_levels.standby_level);
                end
            end
            MODE_RECONNECT: begin
                if (recon_on) begin
                    pat.green = i_levels.dim_level;
                    pat.blue  = i_levels.dim_level;
                end
            end
            MODE_PAIRING: begin
                if (i_phases.pairing < PAIRING_ON) pat.blue = i_levels.dim_level;
            end
            MODE_CONNECTED: begin
                pat.green = i_levels.dim_level;
            end
            MODE_FATAL: begin
                if (fatal_on) pat.red = i_levels.max_level;
            end
            default: begin
                pat = '0;   // off and the unused codes stay dark
            end
        endcase
        if (i_overlay) begin
            pat.red   = i_levels.max_level;
            pat.green = i_levels.max_level;
            pat.blue  = i_levels.max_level;
        end
    end

    assign o_rgb = pat;

endmodule

### rtl/status_led_pattern_generator.sv
// Channel  | Dir | Handshake               | Payload
// ---------+-----+-------------------------+------------------------------------------
// s_axis   | in  | tvalid / tready         | tdata: new_mode, pulse_length; tuser: op
// m_axis   | out | tvalid / tready         | tdata: red, green, blue; tuser: overlay_on
// cfg      | in  | valid / ready (always 1)| index, data
//
// One request per cycle while tready is high: the state update and colour lookup
// sit combinationally between the state registers and the output register. A
// skid register behind the output holds one more result when the output stalls,
// so tready only drops once two results wait downstream.
// Synchronous active-low reset clears state and restores register defaults.
module status_led_pattern_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // [2:0] new_mode, [18:3] pulse_length, rest zero
    input  logic [1:0]  i_s_axis_tuser,  // [1:0] operation
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,  // [7:0] red, [15:8] green, [23:16] blue
    output logic        o_m_axis_tuser,  // [0] overlay_on
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [sledg_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [sledg_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import sledg_pkg::*;

    logic [LEVEL_W-1:0] r_standby_level, r_dim_level, r_max_level;
    logic [MS_W-1:0]    r_act_pulse_ms, r_act_gap_ms;

    logic [TIME_W-1:0]  r_time_ms, n_time_ms;
    logic [TIME_W-1:0]  r_last_act, n_last_act;
    t_phases            r_phases, n_phases;
    logic [2:0]         r_mode, n_mode;
    logic [MS_W-1:0]    r_overlay_left, n_overlay_left;

    logic               r_out_valid, r_skid_valid;
    t_rgb               r_out_rgb, r_skid_rgb;
    logic               r_out_ovl, r_skid_ovl;

    logic               in_acc, out_pop;
    logic [1:0]         op;
    logic [2:0]         in_mode;
    logic [MS_W-1:0]    in_len;
    logic [TIME_W-1:0]  act_gap;
    logic [11:0]        sb_nx;
    logic [10:0]        rc_nx;
    logic [9:0]         pr_nx, ft_nx;
    t_levels            levels;
    t_rgb               res_rgb;
    logic               res_ovl;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = !r_skid_valid;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_pop         = r_out_valid && i_m_axis_tready;

    assign op      = i_s_axis_tuser;
    assign in_mode = i_s_axis_tdata[2:0];
    assign in_len  = i_s_axis_tdata[18:3];
    assign act_gap = r_time_ms - r_last_act;

    assign sb_nx = r_phases.standby + 12'd1;
    assign rc_nx = r_phases.reconnect + 11'd1;
    assign pr_nx = r_phases.pairing + 10'd1;
    assign ft_nx = r_phases.fatal + 10'd1;

    always_comb begin
        n_time_ms      = r_time_ms;
        n_last_act     = r_last_act;
        n_phases       = r_phases;
        n_mode         = r_mode;
        n_overlay_left = r_overlay_left;
        case (op)
            OP_TICK: begin
                n_time_ms          = r_time_ms + 32'd1;
                n_phases.standby   = (sb_nx >= STANDBY_PERIOD)   ? '0 : sb_nx;
                n_phases.reconnect = (rc_nx >= RECONNECT_PERIOD) ? '0 : rc_nx;
                n_phases.pairing   = (pr_nx >= PAIRING_PERIOD)   ? '0 : pr_nx;
                n_phases.fatal     = (ft_nx >= FATAL_PERIOD)     ? '0 : ft_nx;
                if (r_overlay_left != '0) n_overlay_left = r_overlay_left - 16'd1;
            end
            OP_SET_MODE: begin
                n_mode = in_mode;
            end
            OP_PULSE: begin
                if (in_len > r_overlay_left) n_overlay_left = in_len;
            end
            OP_ACTIVITY: begin
                if (act_gap >= {16'd0, r_act_gap_ms}) begin
                    n_last_act = r_time_ms;
                    if (r_act_pulse_ms > r_overlay_left) n_overlay_left = r_act_pulse_ms;
                end
            end
            default: begin
                n_mode = r_mode;
            end
        endcase
    end

    assign levels  = '{standby_level: r_standby_level, dim_level: r_dim_level,
                       max_level: r_max_level};
    assign res_ovl = (n_overlay_left != '0);

    sledg_colour u_colour (
        .i_mode    (n_mode),
        .i_phases  (n_phases),
        .i_levels  (levels),
        .i_overlay (res_ovl),
        .o_rgb     (res_rgb)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_standby_level <= 8'd32;
            r_dim_level     <= 8'd16;
            r_max_level     <= 8'd255;
            r_act_pulse_ms  <= 16'd35;
            r_act_gap_ms    <= 16'd90;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_STANDBY_LEVEL: r_standby_level <= i_cfg_data[LEVEL_W-1:0];
                CFG_DIM_LEVEL:     r_dim_level     <= i_cfg_data[LEVEL_W-1:0];
                CFG_MAX_LEVEL:     r_max_level     <= i_cfg_data[LEVEL_W-1:0];
                CFG_ACT_PULSE_MS:  r_act_pulse_ms  <= i_cfg_data;
                CFG_ACT_GAP_MS:    r_act_gap_ms    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_ms      <= '0;
            r_last_act     <= '0;
            r_phases       <= '0;
            r_mode         <= MODE_OFF;
            r_overlay_left <= '0;
        end else if (in_acc) begin
            r_time_ms      <= n_time_ms;
            r_last_act     <= n_last_act;
            r_phases       <= n_phases;
            r_mode         <= n_mode;
            r_overlay_left <= n_overlay_left;
        end
    end

    // output register with one skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= in_acc;
            end
        end else if (in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_pop) begin
            if (r_skid_valid) begin
                r_out_rgb <= r_skid_rgb;
                r_out_ovl <= r_skid_ovl;
            end else begin
                r_out_rgb <= res_rgb;
                r_out_ovl <= res_ovl;
            end
        end else if (in_acc) begin
            r_skid_rgb <= res_rgb;
            r_skid_ovl <= res_ovl;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_rgb;
    assign o_m_axis_tuser  = r_out_ovl;

endmodule

### rtl/sledg_checker.sv
module sledg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser
);

    // overlay shows white: all three channels at the same level
    a_overlay_white: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |->
        (o_m_axis_tdata[7:0] == o_m_axis_tdata[15:8]) &&
        (o_m_axis_tdata[15:8] == o_m_axis_tdata[23:16]))
        else $error("overlay colour is not white");

    // back-pressure only once the output register is occupied
    a_ready_low_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid)
        else $error("input stalled with empty output");

    // every accepted request leaves a result waiting next cycle
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> o_m_axis_tvalid)
        else $error("accepted request produced no result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind status_led_pattern_generator sledg_checker u_sledg_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
